[hw/rtl/baes_pkg.sv]
// Shared constants for the box-average and exponential smoother block.
`default_nettype none

package baes_pkg;

  // Field widths of the stream and configuration payloads.
  localparam int unsigned SampleW = 12;
  localparam int unsigned AvgW    = 12;
  localparam int unsigned SmoothW = 28;
  localparam int unsigned WeightW = 17;

  // Byte-padded widths of the stream data buses.
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 40;

  // Default structural parameters.
  localparam int unsigned WindowDef     = 10;
  localparam int unsigned SampleBitsDef = 12;

  // Filter arithmetic: Q1.16 weight, unity weight and the reset weight (about 0.1).
  localparam int unsigned FracBits = 16;
  localparam logic [WeightW-1:0] WeightOne   = 17'h10000;
  localparam logic [WeightW-1:0] WeightReset = 17'd6554;

endpackage

`default_nettype wire

[hw/rtl/baes_ram.sv]
// Generic single-port RAM with read-first behavior and a registered read port.
`default_nettype none

module baes_ram #(
  parameter int unsigned Width = 12,
  parameter int unsigned Depth = 10
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // The read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem_q[addr_i];
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/box_average_then_ema_smoother_unit.sv]
// Top level of the box-average then exponential smoother.
//
// Usage: each sample arrives as one transfer on the s_axis channel and gives
// exactly one result transfer on the m_axis channel, in order. A result holds
// the truncated mean of the last Window samples and the low-pass filtered
// mean in unsigned Q12.16. The filter weight is written over the cfg channel
// (Q1.16, values above 65536 act as 65536). The user must write it only while
// the block is idle; the block itself does not enforce this.
//
// Throughput is one sample per cycle unless the receiver stalls: the history
// ring is a RAM read and written at the same slot in the accept cycle, the
// running total and the filter state each feed back through a register, and the
// divide by Window is a reciprocal multiply plus a correction over two pipeline stages.
//
// Reset clears the ring (through a wrap flag, not by sweeping the RAM), the
// write slot, the running total and the filter state, and sets the weight to
// about 0.1. When the receiver stalls, the pipeline keeps filling its empty
// stages and s_axis_tready drops only once every stage holds an item.
`default_nettype none

module box_average_then_ema_smoother_unit #(
  parameter int unsigned Window     = baes_pkg::WindowDef,
  parameter int unsigned SampleBits = baes_pkg::SampleBitsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Sample stream. tdata: [11:0] sample, upper bits zero.
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [baes_pkg::InDataW-1:0]   s_axis_tdata,
  // Result stream. tdata: [11:0] window_average, [39:12] smoothed_value.
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [baes_pkg::OutDataW-1:0]  m_axis_tdata,
  // Weight register write channel. data: [16:0] smoothing_weight.
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [baes_pkg::WeightW-1:0]   cfg_data_i
);

  localparam int unsigned SlotW   = $clog2(Window);
  localparam int unsigned TotalW  = SampleBits + $clog2(Window);
  localparam int unsigned SmW     = SampleBits + baes_pkg::FracBits;
  localparam int unsigned WW      = baes_pkg::WeightW;
  localparam int unsigned AccW    = WW + SampleBits;
  localparam int unsigned TermW   = WW + SmW;
  // Truncated reciprocal of Window, scaled so the quotient estimate is short by at most one.
  localparam logic [TotalW-1:0] Recip = TotalW'((64'd1 << TotalW) / Window);

  // Input handshake and sample.
  logic                  accept;
  logic [SampleBits-1:0] sample;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign sample = SampleBits'(s_axis_tdata[baes_pkg::SampleW-1:0]);

  // Control and state registers.
  logic [5:1]         valid_q;
  logic               out_valid_q;
  logic [SlotW-1:0]   slot_q;
  logic               wrapped_q;
  logic [TotalW-1:0]  total_q;
  logic [SmW-1:0]     smooth_q;
  logic [WW-1:0]      weight_q;
  logic [WW-1:0]      inv_weight_q;

  // Stage payload registers.
  logic [SampleBits-1:0] s1_sample_q;
  logic                  s1_old_ok_q;
  logic [TotalW-1:0]     s2_total_q;
  logic [2*TotalW-1:0]   s3_prod_q;
  logic [TotalW-1:0]     s3_total_q;
  logic [SampleBits-1:0] s4_avg_q;
  logic [AccW-1:0]       s5_term_q;
  logic [SampleBits-1:0] s5_avg_q;
  logic [SampleBits-1:0] out_avg_q;

  // Stage k can take a new item when it is empty or its item moves on.
  logic [6:1] free;

  always_comb begin
    free[6] = !out_valid_q || m_axis_tready;
    for (int k = 5; k >= 1; k--) begin
      free[k] = !valid_q[k] || free[k+1];
    end
  end

  assign s_axis_tready = free[1];

  // History ring: read the oldest sample and overwrite it in the same cycle.
  logic [SampleBits-1:0] ring_rdata;

  baes_ram #(
    .Width (SampleBits),
    .Depth (Window)
  ) u_ring (
    .clk_i   (clk_i),
    .en_i    (accept),
    .we_i    (accept),
    .addr_i  (slot_q),
    .wdata_i (sample),
    .rdata_o (ring_rdata)
  );

  // Stage 1: running total update; entries not yet written since reset read as zero.
  logic [SampleBits-1:0] old_sample;
  logic [TotalW-1:0]     total_new;

  assign old_sample = s1_old_ok_q ? ring_rdata : '0;
  assign total_new  = total_q - TotalW'(old_sample) + TotalW'(s1_sample_q);

  // Stage 3: correct the reciprocal estimate by one compare and add.
  logic [SampleBits-1:0] quot_est;
  logic [TotalW-1:0]     remainder;
  logic [SampleBits-1:0] avg_fixed;

  assign quot_est  = SampleBits'(s3_prod_q >> TotalW);
  assign remainder = s3_total_q - TotalW'(quot_est * Window);
  assign avg_fixed = quot_est + SampleBits'(remainder >= TotalW'(Window));

  // Stage 5: filter step, new = w*avg + ((1-w)*old >> 16).
  logic [TermW-1:0] decay_prod;
  logic [SmW-1:0]   smooth_new;

  assign decay_prod = TermW'(inv_weight_q) * TermW'(smooth_q);
  assign smooth_new = SmW'(TermW'(s5_term_q) + (decay_prod >> baes_pkg::FracBits));

  // Weight saturation applied at the register write.
  logic [WW-1:0] weight_sat;

  assign weight_sat  = (cfg_data_i > baes_pkg::WeightOne) ? baes_pkg::WeightOne : cfg_data_i;
  assign cfg_ready_o = 1'b1;

  // Control state, running total, filter state and weight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
      slot_q       <= '0;
      wrapped_q    <= 1'b0;
      total_q      <= '0;
      smooth_q     <= '0;
      weight_q     <= baes_pkg::WeightReset;
      inv_weight_q <= baes_pkg::WeightOne - baes_pkg::WeightReset;
    end else begin
      if (free[1]) valid_q[1] <= accept;
      for (int k = 2; k <= 5; k++) begin
        if (free[k]) valid_q[k] <= valid_q[k-1];
      end
      if (free[6]) out_valid_q <= valid_q[5];

      if (accept) begin
        if (slot_q == SlotW'(Window - 1)) begin
          slot_q    <= '0;
          wrapped_q <= 1'b1;
        end else begin
          slot_q <= slot_q + 1'b1;
        end
      end

      if (valid_q[1] && free[2]) total_q <= total_new;
      if (valid_q[5] && free[6]) smooth_q <= smooth_new;

      if (cfg_valid_i && cfg_ready_o) begin
        weight_q     <= weight_sat;
        inv_weight_q <= baes_pkg::WeightOne - weight_sat;
      end
    end
  end

  // Pipeline payload; each stage loads whenever it is free.
  always_ff @(posedge clk_i) begin
    if (free[1]) begin
      s1_sample_q <= sample;
      s1_old_ok_q <= wrapped_q;
    end
    if (free[2]) s2_total_q <= total_new;
    if (free[3]) begin
      s3_prod_q  <= (2*TotalW)'(s2_total_q) * (2*TotalW)'(Recip);
      s3_total_q <= s2_total_q;
    end
    if (free[4]) s4_avg_q <= avg_fixed;
    if (free[5]) begin
      s5_term_q <= AccW'(weight_q) * AccW'(s4_avg_q);
      s5_avg_q  <= s4_avg_q;
    end
    if (free[6]) out_avg_q <= s5_avg_q;
  end

  // Result transfer; the filter state is the smoothed field of the held result.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {baes_pkg::SmoothW'(smooth_q), baes_pkg::AvgW'(out_avg_q)};

  // The write slot stays inside the ring.
  assert property (@(posedge clk_i) disable iff (!rst_ni) slot_q < SlotW'(Window))
    else $error("write slot outside the ring");

  // With no result held, every stage can move, so a sample is always taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !out_valid_q |-> s_axis_tready)
    else $error("input stalled with an empty output");

  // The running total never exceeds the largest possible ring sum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TotalW'(Window * ((1 << SampleBits) - 1)))
    else $error("running total out of range");

  // The quotient estimate is short by at most one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[3] |-> remainder < TotalW'(2 * Window))
    else $error("division correction out of range");

  // A result appears only after the final stage held an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(valid_q[5]))
    else $error("result without a source item");

endmodule

`default_nettype wire
